// ----- hdl/mpfg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfg_pkg
// Shared types, constants and the level-to-width mapping of the motor pulse
// frame generator.
// ----------------------------------------------------------------------------
package mpfg_pkg;

    localparam int MOTORS        = 4;
    localparam int QUEUE_DEPTH   = 2;

    // event codes
    typedef enum logic [1:0] {
        OP_LINK_SAMPLE  = 2'd0,
        OP_TEST_SET     = 2'd1,
        OP_TEST_RELEASE = 2'd2,
        OP_RUN_CYCLE    = 2'd3
    } t_op;

    // configuration register indexes
    localparam logic [1:0] REG_PULSE_MIN      = 2'd0;
    localparam logic [1:0] REG_PULSE_MAX      = 2'd1;
    localparam logic [1:0] REG_PULSE_DISARMED = 2'd2;
    localparam logic [1:0] REG_LINK_TIMEOUT   = 2'd3;

    localparam logic [15:0] RST_PULSE_MIN      = 16'd1000;
    localparam logic [15:0] RST_PULSE_MAX      = 16'd2000;
    localparam logic [15:0] RST_PULSE_DISARMED = 16'd1000;
    localparam logic [31:0] RST_LINK_TIMEOUT   = 32'd500000;

    // frame layout
    localparam logic [7:0] SYNC_0      = 8'hAA;
    localparam logic [7:0] SYNC_1      = 8'h55;
    localparam logic [7:0] MOTOR_COUNT = 8'h04;

    localparam logic [3:0] BYTE_SYNC_0 = 4'd0;
    localparam logic [3:0] BYTE_SYNC_1 = 4'd1;
    localparam logic [3:0] BYTE_COUNT  = 4'd2;
    localparam logic [3:0] BYTE_W0     = 4'd3;
    localparam logic [3:0] BYTE_CSUM   = 4'd11;

    // Q3.12 mapping constants
    localparam logic signed [15:0] LVL_NEG_LIMIT = -16'sd4096;
    localparam logic signed [15:0] LVL_POS_LIMIT = 16'sd4096;
    localparam logic signed [23:0] NEG_BASE      = 24'sd6144000;
    localparam logic signed [23:0] NEG_GAIN      = 24'sd500;
    localparam logic signed [23:0] POS_BASE      = 24'sd4096000;
    localparam logic signed [23:0] POS_GAIN      = 24'sd1000;

    typedef logic [MOTORS-1:0][15:0] t_widths;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Map a level to an unclamped width; result never exceeds 2000.
    function automatic logic [10:0] f_map_level(input logic signed [15:0] lvl);
        logic signed [13:0] c;
        logic signed [23:0] sum;
        if (lvl < 16'sd0) begin
            c   = (lvl < LVL_NEG_LIMIT) ? 14'(LVL_NEG_LIMIT) : 14'(lvl);
            sum = NEG_BASE + 24'(c) * NEG_GAIN;
        end else begin
            c   = (lvl > LVL_POS_LIMIT) ? 14'(LVL_POS_LIMIT) : 14'(lvl);
            sum = POS_BASE + 24'(c) * POS_GAIN;
        end
        return sum[22:12];
    endfunction

endpackage

// ----- hdl/mpfg_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfg_front
// Accepts events, keeps overrides, link time and configuration, and pushes
// the four widths of every frame to be sent into the frame queue.
// ----------------------------------------------------------------------------
module mpfg_front
    import mpfg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_operation,
    input  logic [31:0]        i_now_us,
    input  logic               i_link_valid,
    input  logic [3:0]         i_motor_number,
    input  logic signed [15:0] i_test_level,
    input  logic               i_motors_new,
    input  logic signed [15:0] i_command_0,
    input  logic signed [15:0] i_command_1,
    input  logic signed [15:0] i_command_2,
    input  logic signed [15:0] i_command_3,
    input  logic [3:0]         i_finite_mask,
    input  logic               i_wr_en,
    input  logic [1:0]         i_wr_index,
    input  logic [31:0]        i_wr_data,
    input  t_q_status          i_q_status,
    output logic               o_q_push,
    output t_widths            o_q_data
);

    logic [15:0] r_pulse_min;
    logic [15:0] r_pulse_max;
    logic [15:0] r_pulse_disarmed;
    logic [31:0] r_link_timeout;

    logic [MOTORS-1:0]              r_slot_set;
    logic signed [MOTORS-1:0][15:0] r_slot_level;
    logic [31:0]                    r_last_link;
    logic                           r_link_seen;

    // stage between decode and clamp
    logic                    r_s1_valid;
    logic [MOTORS-1:0]       r_s1_arm;
    logic [MOTORS-1:0][10:0] r_s1_raw;

    logic                           accept;
    t_op                            op;
    logic                           any_slot;
    logic                           timed_out;
    logic                           need_frame;
    logic signed [MOTORS-1:0][15:0] cmd;
    logic [MOTORS-1:0]              n_arm;
    logic [MOTORS-1:0][10:0]        n_raw;
    logic [31:0]                    elapsed;

    assign op       = t_op'(i_operation);
    assign o_stall  = r_s1_valid && i_q_status.full;
    assign accept   = i_valid && !o_stall;
    assign o_q_push = r_s1_valid && !i_q_status.full;
    assign any_slot = |r_slot_set;
    assign elapsed  = i_now_us - r_last_link;
    assign timed_out = r_link_seen && (elapsed > r_link_timeout);
    assign cmd = {i_command_3, i_command_2, i_command_1, i_command_0};

    always_comb begin
        need_frame = 1'b0;
        n_arm      = '0;
        for (int i = 0; i < MOTORS; i++) begin
            n_raw[i] = f_map_level(any_slot ? r_slot_level[i] : cmd[i]);
        end
        unique case (op)
            OP_TEST_RELEASE: begin
                need_frame = 1'b1;
            end
            OP_RUN_CYCLE: begin
                if (any_slot) begin
                    need_frame = 1'b1;
                    n_arm      = r_slot_set;
                end else if (i_motors_new) begin
                    need_frame = 1'b1;
                    // drop to a disarmed frame on link loss
                    n_arm      = timed_out ? '0 : i_finite_mask;
                end
            end
            default: begin
                need_frame = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_min      <= RST_PULSE_MIN;
            r_pulse_max      <= RST_PULSE_MAX;
            r_pulse_disarmed <= RST_PULSE_DISARMED;
            r_link_timeout   <= RST_LINK_TIMEOUT;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                REG_PULSE_MIN:      r_pulse_min      <= i_wr_data[15:0];
                REG_PULSE_MAX:      r_pulse_max      <= i_wr_data[15:0];
                REG_PULSE_DISARMED: r_pulse_disarmed <= i_wr_data[15:0];
                REG_LINK_TIMEOUT:   r_link_timeout   <= i_wr_data;
                default:            r_link_timeout   <= r_link_timeout;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_set  <= '0;
            r_last_link <= '0;
            r_link_seen <= 1'b0;
            r_s1_valid  <= 1'b0;
        end else begin
            if (accept) begin
                unique case (op)
                    OP_LINK_SAMPLE: begin
                        if (i_link_valid) begin
                            r_last_link <= i_now_us;
                            r_link_seen <= 1'b1;
                        end
                    end
                    OP_TEST_SET: begin
                        if (i_motor_number < 4'(MOTORS)) begin
                            r_slot_set[i_motor_number[1:0]]   <= i_finite_mask[0];
                            r_slot_level[i_motor_number[1:0]] <=
                                i_finite_mask[0] ? i_test_level : 16'sd0;
                        end
                    end
                    OP_TEST_RELEASE: begin
                        r_slot_set   <= '0;
                        r_slot_level <= '0;
                    end
                    default: begin
                        r_slot_set <= r_slot_set;
                    end
                endcase
            end
            if (accept && need_frame) begin
                r_s1_valid <= 1'b1;
            end else if (o_q_push) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && need_frame) begin
            r_s1_arm <= n_arm;
            r_s1_raw <= n_raw;
        end
    end

    // raise to the minimum, then lower to the maximum
    always_comb begin
        logic [15:0] w;
        for (int i = 0; i < MOTORS; i++) begin
            w = {5'd0, r_s1_raw[i]};
            if (w < r_pulse_min) begin
                w = r_pulse_min;
            end
            if (w > r_pulse_max) begin
                w = r_pulse_max;
            end
            o_q_data[i] = r_s1_arm[i] ? w : r_pulse_disarmed;
        end
    end

endmodule

// ----- hdl/mpfg_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfg_queue
// Short queue of pending frames between the event front end and the byte
// serializer.
// ----------------------------------------------------------------------------
module mpfg_queue
    import mpfg_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_widths   i_data,
    input  logic      i_pop,
    output t_widths   o_data,
    output t_q_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_widths            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    function automatic logic [PTR_W-1:0] f_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_data         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= f_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= f_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.full |-> !i_push || i_pop)
        else $error("frame queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.empty |-> !i_pop)
        else $error("frame queue underflow");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("frame queue count lost a push");
`endif

endmodule

// ----- hdl/mpfg_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfg_back
// Serializes one queued frame into twelve bytes: sync, count, four
// big-endian widths and the XOR checksum.
// ----------------------------------------------------------------------------
module mpfg_back
    import mpfg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_status i_q_status,
    input  t_widths   i_q_data,
    output logic      o_q_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output logic [7:0] o_frame_byte,
    output logic      o_frame_last
);

    t_widths     r_frame;
    logic        r_busy;
    logic [3:0]  r_idx;
    logic [7:0]  r_xor;
    logic        r_valid;
    logic [7:0]  r_byte;
    logic        r_last;

    logic        advance;
    logic        emit;
    logic [7:0]  cur_byte;
    logic [3:0]  k;

    assign advance = !r_valid || !i_stall;
    assign emit    = advance && r_busy;
    assign o_q_pop = advance && (!r_busy || r_idx == BYTE_CSUM) && !i_q_status.empty;
    assign k       = r_idx - BYTE_W0;

    always_comb begin
        unique case (r_idx)
            BYTE_SYNC_0: cur_byte = SYNC_0;
            BYTE_SYNC_1: cur_byte = SYNC_1;
            BYTE_COUNT:  cur_byte = MOTOR_COUNT;
            BYTE_CSUM:   cur_byte = r_xor;
            default: begin
                // high byte first
                cur_byte = k[0] ? r_frame[k[2:1]][7:0] : r_frame[k[2:1]][15:8];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_valid <= 1'b1;
            end else if (advance) begin
                r_valid <= 1'b0;
            end
            // a pop on the checksum byte starts the next frame at once
            if (o_q_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (emit) begin
                r_idx <= r_idx + 1'b1;
                if (r_idx == BYTE_CSUM) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte <= cur_byte;
            r_last <= (r_idx == BYTE_CSUM);
        end
        if (o_q_pop) begin
            r_frame <= i_q_data;
            r_xor   <= '0;
        end else if (emit) begin
            r_xor <= r_xor ^ cur_byte;
        end
    end

    assign o_valid      = r_valid;
    assign o_frame_byte = r_byte;
    assign o_frame_last = r_last;

endmodule

// ----- hdl/motor_pwm_frame_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_pwm_frame_generator
// Turns link, test and run events into 12-byte motor pulse-width frames.
// ----------------------------------------------------------------------------
// The input side takes one event word per cycle as long as the frame queue
// has room; events that send no frame finish in that cycle. Each frame
// leaves as twelve output words, one per cycle while the output is not
// stalled, and frames follow each other with no gap while the queue holds
// more. Widths are mapped as the event is taken and clamped in the next
// cycle; the words of a frame then pass through the frame queue and the
// byte serializer's output register. Configuration writes take effect at
// once and are meant for idle periods only.
// ----------------------------------------------------------------------------
module motor_pwm_frame_generator
    import mpfg_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_operation,
    input  logic [31:0]        i_now_us,
    input  logic               i_link_valid,
    input  logic [3:0]         i_motor_number,
    input  logic signed [15:0] i_test_level,
    input  logic               i_motors_new,
    input  logic signed [15:0] i_command_0,
    input  logic signed [15:0] i_command_1,
    input  logic signed [15:0] i_command_2,
    input  logic signed [15:0] i_command_3,
    input  logic [3:0]         i_finite_mask,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_frame_byte,
    output logic               o_frame_last,
    input  logic               i_wr_en,
    input  logic [1:0]         i_wr_index,
    input  logic [31:0]        i_wr_data
);

    t_q_status q_status;
    t_widths   q_in;
    t_widths   q_out;
    logic      q_push;
    logic      q_pop;

    mpfg_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_now_us       (i_now_us),
        .i_link_valid   (i_link_valid),
        .i_motor_number (i_motor_number),
        .i_test_level   (i_test_level),
        .i_motors_new   (i_motors_new),
        .i_command_0    (i_command_0),
        .i_command_1    (i_command_1),
        .i_command_2    (i_command_2),
        .i_command_3    (i_command_3),
        .i_finite_mask  (i_finite_mask),
        .i_wr_en        (i_wr_en),
        .i_wr_index     (i_wr_index),
        .i_wr_data      (i_wr_data),
        .i_q_status     (q_status),
        .o_q_push       (q_push),
        .o_q_data       (q_in)
    );

    mpfg_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_data   (q_in),
        .i_pop    (q_pop),
        .o_data   (q_out),
        .o_status (q_status)
    );

    mpfg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_status   (q_status),
        .i_q_data     (q_out),
        .o_q_pop      (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_frame_byte (o_frame_byte),
        .o_frame_last (o_frame_last)
    );

endmodule
